[rtl/hybrid_clock_commit_timeline_assert.svh]
// Assertion macros shared by the timeline design.
// Both expect clk and arst_n in the scope where they are used.
`ifndef HYBRID_CLOCK_COMMIT_TIMELINE_ASSERT_SVH
`define HYBRID_CLOCK_COMMIT_TIMELINE_ASSERT_SVH

// Same-cycle implication.
`define HCCT_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcct assertion failed");

// Next-cycle implication.
`define HCCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcct assertion failed");

`endif

[rtl/hcct_pkg.sv]
package hcct_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int OUT_CNT_W = 17;

	localparam logic [2:0] ACT_CLEAR   = 3'd0;
	localparam logic [2:0] ACT_ALLOC   = 3'd1;
	localparam logic [2:0] ACT_APPEND  = 3'd2;
	localparam logic [2:0] ACT_RESTORE = 3'd3;
	localparam logic [2:0] ACT_RESOLVE = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ORDER    = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [63:0] PHYS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] LOG_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [63:0] physical;
		logic [31:0] logical;
	} clock_t;

	// Clocks order by the physical part first, then by the logical counter.
	function automatic logic clock_above(clock_t a, clock_t b);
		return (a.physical > b.physical) ||
			((a.physical == b.physical) && (a.logical > b.logical));
	endfunction

endpackage

[rtl/hcct_if.sv]
interface hcct_req_if;
	import hcct_pkg::*;

	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] time_us;
	logic [63:0] seq;
	logic [63:0] hlc_physical;
	logic [31:0] hlc_logical;

	modport source (output valid, action, time_us, seq, hlc_physical, hlc_logical,
		input ready);
	modport sink (input valid, action, time_us, seq, hlc_physical, hlc_logical,
		output ready);
endinterface

interface hcct_rsp_if;
	import hcct_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [63:0]          clock_physical_out;
	logic [31:0]          clock_logical_out;
	logic [OUT_CNT_W-1:0] resolved_seq;
	logic [OUT_CNT_W-1:0] entries_held;

	modport source (output valid, status, clock_physical_out, clock_logical_out,
		resolved_seq, entries_held, input ready);
	modport sink (input valid, status, clock_physical_out, clock_logical_out,
		resolved_seq, entries_held, output ready);
endinterface

[rtl/hcct_mem.sv]
module hcct_mem #(
	parameter int DEPTH = hcct_pkg::CAPACITY_DEF
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output hcct_pkg::clock_t                      rd_data,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  hcct_pkg::clock_t                      wr_data
);
	import hcct_pkg::*;

	clock_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/hcct_engine.sv]
module hcct_engine #(
	parameter int CAPACITY = hcct_pkg::CAPACITY_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	hcct_req_if.sink                                    req,
	hcct_rsp_if.source                                  rsp,
	output logic                                        rd_en,
	output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
	input  hcct_pkg::clock_t                            rd_data,
	output logic                                        wr_en,
	output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
	output hcct_pkg::clock_t                            wr_data
);
	import hcct_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_ALLOC  = 4'd2;
	localparam logic [3:0] S_APPEND = 4'd3;
	localparam logic [3:0] S_RPREV  = 4'd4;
	localparam logic [3:0] S_RCUR   = 4'd5;
	localparam logic [3:0] S_SRCH   = 4'd6;
	localparam logic [3:0] S_SCMP   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0]  state_q, state_d;
	logic [CW-1:0] total_q, total_d;
	logic        out_valid_q;
	logic        in_ld, out_ld, res_ld, do_push;

	logic [2:0]  action_q;
	logic [63:0] time_q, seq_q;
	clock_t      cur_q;

	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q;
	logic          mid_ld;
	logic [CW:0]   mid_sum;

	logic [2:0]           res_status_d, res_status_q;
	logic [63:0]          res_cp_d, res_cp_q;
	logic [31:0]          res_cl_d, res_cl_q;
	logic [OUT_CNT_W-1:0] res_rs_d, res_rs_q;

	logic [2:0]           out_status_q;
	logic [63:0]          out_cp_q;
	logic [31:0]          out_cl_q;
	logic [OUT_CNT_W-1:0] out_rs_q, out_held_q;

	logic [63:0] total_w, seq_next, seq_m1, seq_m2;
	logic [CW-1:0] total_m1;
	logic          table_full;

	assign total_w    = 64'(total_q);
	assign seq_next   = total_w + 64'd1;
	assign seq_m1     = seq_q - 64'd1;
	assign seq_m2     = seq_q - 64'd2;
	assign total_m1   = total_q - CW'(1);
	assign table_full = (total_q == CW'(CAPACITY));
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};

	assign req.ready = (state_q == S_IDLE);
	assign in_ld     = req.valid && (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		total_d      = total_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = total_q[AW-1:0];
		wr_data      = cur_q;
		res_ld       = 1'b0;
		do_push      = 1'b0;
		out_ld       = 1'b0;
		res_status_d = ST_OK;
		res_cp_d     = '0;
		res_cl_d     = '0;
		res_rs_d     = '0;
		lo_d         = lo_q;
		hi_d         = hi_q;
		mid_ld       = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (action_q)
					ACT_CLEAR: begin
						total_d = '0;
						res_ld  = 1'b1;
					end
					ACT_ALLOC: begin
						if (total_q == '0) begin
							res_cp_d = time_q;
							res_ld   = 1'b1;
						end else begin
							rd_en   = 1'b1;
							rd_addr = total_m1[AW-1:0];
							state_d = S_ALLOC;
						end
					end
					ACT_APPEND: begin
						if (seq_q != seq_next) begin
							res_status_d = ST_ORDER;
							res_ld       = 1'b1;
						end else if (total_q == '0) begin
							do_push = 1'b1;
						end else begin
							rd_en   = 1'b1;
							rd_addr = total_m1[AW-1:0];
							state_d = S_APPEND;
						end
					end
					ACT_RESTORE: begin
						if (seq_q == '0 || seq_q > seq_next) begin
							res_status_d = ST_ORDER;
							res_ld       = 1'b1;
						end else if (seq_q > 64'd1) begin
							rd_en   = 1'b1;
							rd_addr = seq_m2[AW-1:0];
							state_d = S_RPREV;
						end else if (total_q != '0) begin
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = S_RCUR;
						end else begin
							do_push = 1'b1;
						end
					end
					ACT_RESOLVE: begin
						// Clocks rise along the table, so the visible entries form a prefix.
						lo_d    = '0;
						hi_d    = (seq_q < total_w) ? seq_q[CW-1:0] : total_q;
						state_d = S_SRCH;
					end
					default: begin
						res_ld = 1'b1;
					end
				endcase
			end
			S_ALLOC: begin
				res_ld = 1'b1;
				if (time_q > rd_data.physical) begin
					res_cp_d = time_q;
				end else if (rd_data.logical == LOG_MAX) begin
					if (rd_data.physical == PHYS_MAX) begin
						res_status_d = ST_OVERFLOW;
					end else begin
						res_cp_d = rd_data.physical + 64'd1;
					end
				end else begin
					res_cp_d = rd_data.physical;
					res_cl_d = rd_data.logical + 32'd1;
				end
			end
			S_APPEND: begin
				if (clock_above(cur_q, rd_data)) begin
					do_push = 1'b1;
				end else begin
					res_status_d = ST_ORDER;
					res_ld       = 1'b1;
				end
			end
			S_RPREV: begin
				if (!clock_above(cur_q, rd_data)) begin
					res_status_d = ST_ORDER;
					res_ld       = 1'b1;
				end else if (seq_q <= total_w) begin
					rd_en   = 1'b1;
					rd_addr = seq_m1[AW-1:0];
					state_d = S_RCUR;
				end else begin
					do_push = 1'b1;
				end
			end
			S_RCUR: begin
				if (rd_data != cur_q) begin
					res_status_d = ST_MISMATCH;
				end
				res_ld = 1'b1;
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					rd_addr = mid_sum[AW:1];
					mid_ld  = 1'b1;
					state_d = S_SCMP;
				end else begin
					res_rs_d = OUT_CNT_W'(lo_q);
					res_ld   = 1'b1;
				end
			end
			S_SCMP: begin
				if (rd_data.physical <= time_q) begin
					lo_d = mid_q + CW'(1);
				end else begin
					hi_d = mid_q;
				end
				state_d = S_SRCH;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (do_push) begin
			res_ld = 1'b1;
			if (table_full) begin
				res_status_d = ST_FULL;
			end else begin
				wr_en   = 1'b1;
				total_d = total_q + CW'(1);
			end
		end
		if (res_ld) begin
			state_d = S_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ld) begin
			action_q       <= req.action;
			time_q         <= req.time_us;
			seq_q          <= req.seq;
			cur_q.physical <= req.hlc_physical;
			cur_q.logical  <= req.hlc_logical;
		end
		lo_q <= lo_d;
		hi_q <= hi_d;
		if (mid_ld) begin
			mid_q <= mid_sum[CW:1];
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_cp_q     <= res_cp_d;
			res_cl_q     <= res_cl_d;
			res_rs_q     <= res_rs_d;
		end
		// The count is already updated when the result reaches this register.
		if (out_ld) begin
			out_status_q <= res_status_q;
			out_cp_q     <= res_cp_q;
			out_cl_q     <= res_cl_q;
			out_rs_q     <= res_rs_q;
			out_held_q   <= OUT_CNT_W'(total_q);
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_status_q;
	assign rsp.clock_physical_out = out_cp_q;
	assign rsp.clock_logical_out  = out_cl_q;
	assign rsp.resolved_seq       = out_rs_q;
	assign rsp.entries_held       = out_held_q;

endmodule

[rtl/hybrid_clock_commit_timeline.sv]
// Clear, allocate on an empty table and append that fails its sequence check or lands in an
// empty table read no table entry; other allocates and appends read the last entry, restore
// reads up to two entries, and resolve runs k binary search probes (at most 11 for 1024
// entries), each via S_SRCH and S_SCMP. Output stalls hold the result in S_DONE. One word
// is in flight at a time; a new word is taken only in S_IDLE.
// Reset clears the entry count and handshake state at once; table contents are left as is.
`include "hybrid_clock_commit_timeline_assert.svh"

module hybrid_clock_commit_timeline #(
	parameter int CAPACITY = hcct_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hcct_req_if.sink   req,
	hcct_rsp_if.source rsp
);
	import hcct_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	clock_t        rd_data, wr_data;

	hcct_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	hcct_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	`HCCT_ASSERT_IMPLY(a_held_bound, rsp.valid, rsp.entries_held <= OUT_CNT_W'(CAPACITY))
	`HCCT_ASSERT_IMPLY(a_resolve_bound, rsp.valid, rsp.resolved_seq <= rsp.entries_held)
	`HCCT_ASSERT_IMPLY(a_fail_zero, rsp.valid && rsp.status != ST_OK, rsp.clock_physical_out == '0 && rsp.clock_logical_out == '0)
	`HCCT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)

endmodule
